FILE: design/line_rasterizer_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

`ifndef ASSERT_OFF
`define LR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line_rasterizer assertion failed");
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line_rasterizer assertion failed");
`else
`define LR_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/lr_pkg.sv
// Types and constants shared by the line rasterizer modules.
package lr_pkg;

    localparam int LR_COORD_W   = 6;
    localparam int LR_DIM_W     = 7;
    localparam int LR_ERR_W     = 9;
    localparam int LR_CFG_IDX_W = 2;
    localparam int LR_QDEPTH    = 2;
    localparam int LR_QPTR_W    = $clog2(LR_QDEPTH);
    localparam int LR_QCNT_W    = $clog2(LR_QDEPTH + 1);

    localparam logic [LR_DIM_W-1:0] LR_DIM_RESET = 7'd64;

    typedef enum logic [LR_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [LR_DIM_W-1:0] width;
        logic [LR_DIM_W-1:0] height;
    } img_cfg_t;

    // One classified segment, ready for stepping.
    typedef struct packed {
        logic [LR_COORD_W-1:0]      x;
        logic [LR_COORD_W-1:0]      y;
        logic [LR_COORD_W-1:0]      xe;
        logic [LR_COORD_W-1:0]      ye;
        logic [LR_COORD_W-1:0]      dx;
        logic [LR_COORD_W-1:0]      dy;
        logic                       x_neg;
        logic                       y_neg;
        logic signed [LR_ERR_W-1:0] err;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: design/lr_if.sv
// Channel interfaces: segment input, pixel output, configuration write.
interface lr_seg_if;
    logic                          valid;
    logic                          ready;
    logic [lr_pkg::LR_COORD_W-1:0] start_x;
    logic [lr_pkg::LR_COORD_W-1:0] start_y;
    logic [lr_pkg::LR_COORD_W-1:0] end_x;
    logic [lr_pkg::LR_COORD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pix_if;
    logic                          valid;
    logic                          ready;
    logic [lr_pkg::LR_COORD_W-1:0] pixel_x;
    logic [lr_pkg::LR_COORD_W-1:0] pixel_y;
    logic                          visible;
    logic                          last;

    modport source (output valid, pixel_x, pixel_y, visible, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, visible, last, output ready);
endinterface

interface lr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lr_pkg::LR_CFG_IDX_W-1:0] index;
    logic [lr_pkg::LR_DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/lr_front.sv
// Front end: accepts segments, clamps endpoints, works out deltas, steps and start error.
module lr_front #(
    parameter int COORD_RANGE = 64
) (
    lr_seg_if.sink           seg,
    input  lr_pkg::q_stat_t  q_stat,
    output lr_pkg::q_push_t  q_push
);
    import lr_pkg::*;

    localparam int TOP = (COORD_RANGE - 1 > (1 << LR_COORD_W) - 1) ?
                         (1 << LR_COORD_W) - 1 : COORD_RANGE - 1;
    localparam logic [LR_COORD_W-1:0] TOP_C = LR_COORD_W'(TOP);

    logic [LR_COORD_W-1:0] xs, ys, xe, ye;
    logic [LR_COORD_W-1:0] dx, dy;
    logic [LR_ERR_W-1:0]   half_dx, half_dy;

    always_comb
    begin
        xs = (seg.start_x > TOP_C) ? TOP_C : seg.start_x;
        ys = (seg.start_y > TOP_C) ? TOP_C : seg.start_y;
        xe = (seg.end_x > TOP_C) ? TOP_C : seg.end_x;
        ye = (seg.end_y > TOP_C) ? TOP_C : seg.end_y;
        dx = (xe > xs) ? xe - xs : xs - xe;
        dy = (ye > ys) ? ye - ys : ys - ye;
        half_dx = LR_ERR_W'(dx >> 1);
        half_dy = LR_ERR_W'(dy >> 1);

        q_push.job.x     = xs;
        q_push.job.y     = ys;
        q_push.job.xe    = xe;
        q_push.job.ye    = ye;
        q_push.job.dx    = dx;
        q_push.job.dy    = dy;
        q_push.job.x_neg = !(xs < xe);
        q_push.job.y_neg = !(ys < ye);
        // x major keeps +dx/2, otherwise the error starts at -dy/2
        q_push.job.err   = (dx > dy) ? signed'(half_dx) : -signed'(half_dy);
        q_push.valid     = seg.valid && !q_stat.full;
    end

    assign seg.ready = !q_stat.full;

endmodule

FILE: design/lr_queue.sv
// Short job queue between front and back end.
`include "line_rasterizer_macros.svh"
module lr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lr_pkg::q_push_t  q_push,
    input  logic             pop,
    output lr_pkg::q_stat_t  q_stat,
    output lr_pkg::job_t     head
);
    import lr_pkg::*;

    job_t                 mem_reg [LR_QDEPTH];
    logic [LR_QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [LR_QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LR_QCNT_W-1:0] count_reg, count_next;
    logic                 do_push, do_pop;

    always_comb
    begin
        q_stat.full  = (count_reg == LR_QCNT_W'(LR_QDEPTH));
        q_stat.empty = (count_reg == '0);
        do_push      = q_push.valid && !q_stat.full;
        do_pop       = pop && !q_stat.empty;
        wr_ptr_next  = do_push ? LR_QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next  = do_pop ? LR_QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next   = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
        head = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.job;
        end
    end

    `LR_ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, count_reg <= LR_QCNT_W'(LR_QDEPTH))
    `LR_ASSERT_NEXT(a_cnt_track, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

FILE: design/lr_back.sv
// Back end: steps the Bresenham error one pixel per cycle into the output register while pix is not stalled.
`include "line_rasterizer_macros.svh"
module lr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  lr_pkg::img_cfg_t  img_cfg,
    input  lr_pkg::q_stat_t   q_stat,
    input  lr_pkg::job_t      head,
    output logic              pop,
    lr_pix_if.source          pix
);
    import lr_pkg::*;

    job_t                  job_reg, job_next;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    logic [LR_COORD_W-1:0] px_reg, py_reg;
    logic                  vis_reg, last_reg;

    logic                  out_free, advance, done;
    logic                  step_x, step_y;
    logic signed [LR_ERR_W-1:0] neg_dx, pos_dy, pos_dx;

    always_comb
    begin
        out_free = !out_valid_reg || pix.ready;
        advance  = busy_reg && out_free;
        done     = (job_reg.x == job_reg.xe) && (job_reg.y == job_reg.ye);
        pop      = !q_stat.empty && (!busy_reg || (advance && done));

        pos_dx = signed'(LR_ERR_W'(job_reg.dx));
        pos_dy = signed'(LR_ERR_W'(job_reg.dy));
        neg_dx = -pos_dx;
        step_x = job_reg.err > neg_dx;
        step_y = job_reg.err < pos_dy;

        job_next = job_reg;
        if (pop)
        begin
            job_next = head;
        end
        else if (advance && !done)
        begin
            job_next.err = job_reg.err - (step_x ? pos_dy : '0) + (step_y ? pos_dx : '0);
            if (step_x)
            begin
                job_next.x = job_reg.x_neg ? job_reg.x - 1'b1 : job_reg.x + 1'b1;
            end
            if (step_y)
            begin
                job_next.y = job_reg.y_neg ? job_reg.y - 1'b1 : job_reg.y + 1'b1;
            end
        end

        busy_next = busy_reg;
        if (pop)
        begin
            busy_next = 1'b1;
        end
        else if (advance && done)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        if (advance)
        begin
            px_reg   <= job_reg.x;
            py_reg   <= job_reg.y;
            vis_reg  <= (LR_DIM_W'(job_reg.x) < img_cfg.width) &&
                        (LR_DIM_W'(job_reg.y) < img_cfg.height);
            last_reg <= done;
        end
    end

    assign pix.valid   = out_valid_reg;
    assign pix.pixel_x = px_reg;
    assign pix.pixel_y = py_reg;
    assign pix.visible = vis_reg;
    assign pix.last    = last_reg;

    `LR_ASSERT_NEXT(a_run_cont, clk, rst_n, advance && !done, busy_reg && out_valid_reg)
    `LR_ASSERT_NEXT(a_last_end, clk, rst_n, advance && done && q_stat.empty, !busy_reg && pix.last)

endmodule

FILE: design/line_rasterizer.sv
// Top level of the Bresenham line rasterizer.
//
//  channel | dir | word                                   | accepted when
//  --------+-----+----------------------------------------+-------------------
//  seg     | in  | start_x, start_y, end_x, end_y         | seg.valid & ready
//  pix     | out | pixel_x, pixel_y, visible, last        | pix.valid & ready
//  cfg     | in  | index, data (0 image_width, 1 height)  | cfg.valid & ready
//
// A segment yields max(|dx|,|dy|)+1 pixels, one pixel per cycle from the back-end
// error stepper; the front classifies one segment per cycle into a two-deep queue.
// Reset: image size 64 x 64, queue empty, no pixel pending.
// A stalled pix channel holds the stepper; seg stalls only when the queue is full.
module line_rasterizer #(
    parameter int COORD_RANGE = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    lr_cfg_if.sink   cfg,
    lr_seg_if.sink   seg,
    lr_pix_if.source pix
);
    import lr_pkg::*;

    img_cfg_t img_cfg_reg, img_cfg_next;
    q_push_t  q_push;
    q_stat_t  q_stat;
    job_t     head;
    logic     pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        img_cfg_next = img_cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IMAGE_WIDTH:  img_cfg_next.width  = cfg.data;
                CFG_IMAGE_HEIGHT: img_cfg_next.height = cfg.data;
                default:          img_cfg_next = img_cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_cfg_reg.width  <= LR_DIM_RESET;
            img_cfg_reg.height <= LR_DIM_RESET;
        end
        else
        begin
            img_cfg_reg <= img_cfg_next;
        end
    end

    lr_front #(
        .COORD_RANGE (COORD_RANGE)
    ) u_front (
        .seg    (seg),
        .q_stat (q_stat),
        .q_push (q_push)
    );

    lr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    lr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .img_cfg (img_cfg_reg),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .pix     (pix)
    );

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the line rasterizer: segments in, predicted pixel runs out.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lr_pkg::*;

    localparam int COORD_MAX   = 63;
    localparam int MAX_RUN     = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 500000;
    localparam int DRAIN_WAIT  = 20;

    // index outside the register list, writes to it must change nothing
    localparam logic [LR_CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic [LR_COORD_W-1:0] x;
        logic [LR_COORD_W-1:0] y;
        logic                  visible;
        logic                  last;
    } pixel_t;

    logic clk;
    logic rst_n;

    lr_cfg_if cfg_ch ();
    lr_seg_if seg_ch ();
    lr_pix_if pix_ch ();

    line_rasterizer #(.COORD_RANGE(64)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .seg   (seg_ch),
        .pix   (pix_ch)
    );

    // image size as the block should see it
    logic [LR_DIM_W-1:0] img_w;
    logic [LR_DIM_W-1:0] img_h;

    pixel_t expected_pixels[$];

    int  mismatch_count;
    int  segments_sent;
    int  pixels_checked;
    int  send_idle_pct;
    int  sink_stall_pct;
    int  cycle_count;
    bit  hold_req;
    logic hold_active;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count,
                     expected_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Expected run of one segment, appended to the pixel store.
    function automatic void rasterize_segment(input logic [LR_COORD_W-1:0] x0,
                                              input logic [LR_COORD_W-1:0] y0,
                                              input logic [LR_COORD_W-1:0] x1,
                                              input logic [LR_COORD_W-1:0] y1);
        int     x;
        int     y;
        int     xe;
        int     ye;
        int     dx;
        int     dy;
        int     step_x;
        int     step_y;
        int     err;
        int     e2;
        int     count;
        bit     done;
        pixel_t p;
        x      = int'(x0);
        y      = int'(y0);
        xe     = int'(x1);
        ye     = int'(y1);
        dx     = (xe > x) ? xe - x : x - xe;
        dy     = (ye > y) ? ye - y : y - ye;
        step_x = (x < xe) ? 1 : -1;
        step_y = (y < ye) ? 1 : -1;
        // error starts at half the major delta, negative unless dx exceeds dy
        err    = (dx > dy) ? dx / 2 : -(dy / 2);
        count  = 0;
        while (count < MAX_RUN)
        begin
            done      = (x == xe) && (y == ye);
            p.x       = x[LR_COORD_W-1:0];
            p.y       = y[LR_COORD_W-1:0];
            p.visible = (x >= 0) && (y >= 0) && (x < int'(img_w)) && (y < int'(img_h));
            p.last    = done;
            expected_pixels.push_back(p);
            count++;
            if (done)
                break;
            e2 = err;
            if (e2 > -dx)
            begin
                err -= dy;
                x   += step_x;
            end
            if (e2 < dy)
            begin
                err += dx;
                y   += step_y;
            end
        end
    endfunction

    // Receiver: checks every accepted pixel word and picks the next ready.
    initial
    begin
        pixel_t exp_pix;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pix_ch.valid && pix_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected pixel x=%0d y=%0d vis=%0b last=%0b", $time,
                             pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.visible, pix_ch.last);
                end
                else
                begin
                    exp_pix = expected_pixels.pop_front();
                    pixels_checked++;
                    if (pix_ch.pixel_x !== exp_pix.x || pix_ch.pixel_y !== exp_pix.y ||
                        pix_ch.visible !== exp_pix.visible || pix_ch.last !== exp_pix.last)
                    begin
                        mismatch_count++;
                        $display("%0t: pixel mismatch exp x=%0d y=%0d vis=%0b last=%0b",
                                 $time, exp_pix.x, exp_pix.y, exp_pix.visible, exp_pix.last);
                        $display("%0t:                act x=%0d y=%0d vis=%0b last=%0b",
                                 $time, pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.visible,
                                 pix_ch.last);
                    end
                end
            end
            pix_ch.ready <= rst_n && !hold_active &&
                            ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long receiver hold-off, started on request from a test.
    initial
    begin
        hold_active = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    task automatic send_segment(input logic [LR_COORD_W-1:0] x0,
                                input logic [LR_COORD_W-1:0] y0,
                                input logic [LR_COORD_W-1:0] x1,
                                input logic [LR_COORD_W-1:0] y1);
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= x0;
        seg_ch.start_y <= y0;
        seg_ch.end_x   <= x1;
        seg_ch.end_y   <= y1;
        do
            @(posedge clk);
        while (!seg_ch.ready);
        rasterize_segment(x0, y0, x1, y1);
        segments_sent++;
    endtask

    task automatic release_seg();
        seg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [LR_CFG_IDX_W-1:0] index,
                             input logic [LR_DIM_W-1:0]     data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (index == CFG_IMAGE_WIDTH)
            img_w = data;
        else if (index == CFG_IMAGE_HEIGHT)
            img_h = data;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [LR_COORD_W-1:0] near_coord(input logic [LR_COORD_W-1:0] c);
        int v;
        v = int'(c) + $urandom_range(14) - 7;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[LR_COORD_W-1:0];
    endfunction

    // Endpoints at the edges, degenerate runs and all eight octants, reset image size.
    task automatic test_directed_segments();
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        send_segment(0, 0, 0, 0);
        send_segment(63, 63, 63, 63);
        send_segment(0, 0, 63, 0);
        send_segment(63, 0, 0, 0);
        send_segment(0, 0, 0, 63);
        send_segment(0, 63, 0, 0);
        send_segment(0, 0, 63, 63);
        send_segment(63, 63, 0, 0);
        send_segment(0, 63, 63, 0);
        send_segment(32, 32, 40, 35);
        send_segment(32, 32, 35, 40);
        send_segment(32, 32, 29, 40);
        send_segment(32, 32, 24, 35);
        send_segment(32, 32, 24, 29);
        send_segment(32, 32, 29, 24);
        send_segment(32, 32, 35, 24);
        send_segment(32, 32, 40, 29);
        send_segment(10, 10, 11, 11);
        send_segment(5, 5, 6, 5);
        release_seg();
        wait_drained();
    endtask

    task automatic test_image_bounds();
        // zero width or height hides everything; 127 shows the whole range
        write_reg(CFG_IMAGE_WIDTH, 7'd0);
        send_segment(0, 0, 63, 20);
        release_seg();
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 7'd127);
        write_reg(CFG_IMAGE_HEIGHT, 7'd0);
        send_segment(63, 0, 0, 63);
        release_seg();
        wait_drained();
        write_reg(CFG_IMAGE_HEIGHT, 7'd127);
        send_segment(0, 63, 63, 0);
        release_seg();
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 7'd1);
        write_reg(CFG_IMAGE_HEIGHT, 7'd1);
        send_segment(0, 0, 5, 3);
        send_segment(3, 0, 0, 3);
        release_seg();
        wait_drained();
        write_reg(CFG_IMAGE_WIDTH, 7'd33);
        write_reg(CFG_IMAGE_HEIGHT, 7'd17);
        // out-of-list index must leave the size alone
        write_reg(CFG_UNUSED_IDX, 7'd0);
        send_segment(20, 10, 45, 30);
        send_segment(40, 5, 25, 50);
        release_seg();
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        logic [LR_COORD_W-1:0] x0;
        logic [LR_COORD_W-1:0] y0;
        logic [LR_COORD_W-1:0] x1;
        logic [LR_COORD_W-1:0] y1;
        write_reg(CFG_IMAGE_WIDTH, 7'($urandom_range(64, 1)));
        write_reg(CFG_IMAGE_HEIGHT, 7'($urandom_range(64, 1)));
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count)
        begin
            x0 = 6'($urandom);
            y0 = 6'($urandom);
            // mostly short segments, some across the whole range
            if ($urandom_range(99) < 70)
            begin
                x1 = near_coord(x0);
                y1 = near_coord(y0);
            end
            else
            begin
                x1 = 6'($urandom);
                y1 = 6'($urandom);
            end
            send_segment(x0, y0, x1, y1);
        end
        release_seg();
        wait_drained();
    endtask

    // Receiver holds off while segments keep coming, then the sender waits for a full drain.
    task automatic test_backpressure();
        write_reg(CFG_IMAGE_WIDTH, 7'd64);
        write_reg(CFG_IMAGE_HEIGHT, 7'd40);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 8; i++)
            send_segment(6'(i), 0, 6'(63 - i), 63);
        release_seg();
        wait_drained();
        send_segment(0, 50, 63, 45);
        send_segment(12, 3, 12, 3);
        send_segment(63, 20, 0, 21);
        release_seg();
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        seg_ch.valid   = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x   = '0;
        seg_ch.end_y   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_IMAGE_WIDTH;
        cfg_ch.data    = '0;
        hold_req       = 1'b0;
        img_w          = LR_DIM_RESET;
        img_h          = LR_DIM_RESET;
        mismatch_count = 0;
        segments_sent  = 0;
        pixels_checked = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        cycle_count    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_segments();
        test_image_bounds();
        test_random_traffic(28, 0, 0);
        test_random_traffic(28, 67, 0);
        test_random_traffic(28, 0, 67);
        test_random_traffic(28, 27, 27);
        test_backpressure();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (expected_pixels.size() != 0)
            mismatch_count++;
        $display("Ran %0d segments, %0d pixels checked, %0d mismatches.", segments_sent,
                 pixels_checked, mismatch_count);
        $display("Covered edge and octant runs, image size extremes, idle mixes and a long stall.");
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/lr_pkg.sv
design/lr_if.sv
design/lr_front.sv
design/lr_queue.sv
design/lr_back.sv
design/line_rasterizer.sv
verif/testbench.sv
